// ===== rtl/polyphase_fir_resampler_defines.svh =====
// ----------------------------------------------------------------------------
// Polyphase FIR resampler assertion macros
// Shared concurrent assertion helpers, clocked on clk_i, held off in reset.
// ----------------------------------------------------------------------------
`ifndef POLYPHASE_FIR_RESAMPLER_DEFINES_SVH
`define POLYPHASE_FIR_RESAMPLER_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define PFR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a trigger implies a consequence on the next edge.
`define PFR_ASSERT_NEXT(label, trig, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/pfr_pkg.sv =====
// ----------------------------------------------------------------------------
// Polyphase FIR resampler package
// Widths, defaults, register indexes and shared types.
// ----------------------------------------------------------------------------
`default_nettype none

package pfr_pkg;

  localparam int SAMPLE_WIDTH     = 16;
  localparam int COEF_WIDTH       = 18;
  localparam int COEF_FRAC        = COEF_WIDTH - 2;
  localparam int DEF_MAX_PHASES   = 32;
  localparam int DEF_MAX_TAPS     = 32;
  localparam int DECIM_MAX        = 64;

  localparam int INTERP_W         = 6;
  localparam int DECIM_W          = 7;
  localparam int TAPS_W           = 6;
  localparam int CFG_ADDR_W       = 2;
  localparam int CFG_DATA_W       = 7;
  localparam int PHASE_IDX_W      = 5;
  localparam int TAP_IDX_W        = 5;
  localparam int S_TDATA_W        = 48;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_INTERP = 2'd0,
    REG_DECIM  = 2'd1,
    REG_TAPS   = 2'd2
  } pfr_reg_e;

  typedef enum logic [0:0] {
    REQ_SAMPLE = 1'b0,
    REQ_COEF   = 1'b1
  } pfr_req_e;

  // Control shared by every tap cell of the delay line.
  typedef struct packed {
    logic shift;   // load from the newer neighbor side (new sample enters)
    logic rotate;  // load from the older neighbor side (ring scan)
  } pfr_cell_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/polyphase_fir_resampler.sv =====
// Sequence: each kept phase is a ring scan of MAX_TAPS cells, a pipeline drain and an
//   output step, after the accumulator is brought below M by repeated subtraction of M
//   in the reduce state, which also decides whether a kept phase follows.
// Throughput: one input sample yields K outputs through the single MAC and the coefficient
//   RAM read port; no new sample or coefficient write is taken until the sample is done.
// Reset (rst_ni low, asynchronous): delay line and phase accumulator cleared,
//   L = 1, M = 1, taps = 32; the coefficient RAM is not cleared.
// ----------------------------------------------------------------------------
// Polyphase FIR rational resampler
// Rational L/M resampler: a ring of tap cells feeds one MAC per kept phase.
// ----------------------------------------------------------------------------
`default_nettype none

module polyphase_fir_resampler
  import pfr_pkg::*;
#(
  parameter int MAX_PHASES = DEF_MAX_PHASES,
  parameter int MAX_TAPS   = DEF_MAX_TAPS
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration write port
  input  logic                             cfg_we_i,
  input  logic [pfr_pkg::CFG_ADDR_W-1:0]   cfg_addr_i,
  input  logic [pfr_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  // input stream
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [15:0] sample_in, [20:16] coef_phase, [25:21] coef_tap, [43:26] coef_value
  input  logic [pfr_pkg::S_TDATA_W-1:0]    s_axis_tdata,
  // [0] req_type
  input  logic                             s_axis_tuser,
  // output stream
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [15:0] sample_out
  output logic [pfr_pkg::SAMPLE_WIDTH-1:0] m_axis_tdata,
  output logic                             m_axis_tlast,
  // [0] saturated
  output logic                             m_axis_tuser
);
  `include "polyphase_fir_resampler_defines.svh"

  localparam int TAP_W  = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int DEPTH  = MAX_PHASES * MAX_TAPS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(MAX_TAPS + 3);
  localparam int NUM_W  = 10;  // wide enough for any phase, tap or count compare

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_REDUCE = 4'b0010,
    S_MAC    = 4'b0100,
    S_FIN    = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers.
  logic [INTERP_W-1:0] interp_q;
  logic [DECIM_W-1:0]  decim_q;
  logic [TAPS_W-1:0]   taps_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interp_q <= INTERP_W'(1);
      decim_q  <= DECIM_W'(1);
      taps_q   <= TAPS_W'(32);
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_INTERP: interp_q <= cfg_wdata_i[INTERP_W-1:0];
        REG_DECIM:  decim_q  <= cfg_wdata_i[DECIM_W-1:0];
        REG_TAPS:   taps_q   <= cfg_wdata_i[TAPS_W-1:0];
        default:    ;  // drop writes to unknown indexes
      endcase
    end
  end

  // Clamp registers into their legal ranges at the time of use.
  logic [NUM_W-1:0] l_eff, m_eff, t_eff;

  always_comb begin
    l_eff = NUM_W'(interp_q);
    if (interp_q == '0) begin
      l_eff = NUM_W'(1);
    end else if (l_eff > NUM_W'(MAX_PHASES)) begin
      l_eff = NUM_W'(MAX_PHASES);
    end
    m_eff = NUM_W'(decim_q);
    if (decim_q == '0) begin
      m_eff = NUM_W'(1);
    end else if (m_eff > NUM_W'(DECIM_MAX)) begin
      m_eff = NUM_W'(DECIM_MAX);
    end
    t_eff = NUM_W'(taps_q);
    if (taps_q == '0) begin
      t_eff = NUM_W'(1);
    end else if (t_eff > NUM_W'(MAX_TAPS)) begin
      t_eff = NUM_W'(MAX_TAPS);
    end
  end

  // Input field split.
  logic [SAMPLE_WIDTH-1:0] in_sample;
  logic [PHASE_IDX_W-1:0]  in_phase;
  logic [TAP_IDX_W-1:0]    in_tap;
  logic [COEF_WIDTH-1:0]   in_coef;

  assign in_sample = s_axis_tdata[15:0];
  assign in_phase  = s_axis_tdata[20:16];
  assign in_tap    = s_axis_tdata[25:21];
  assign in_coef   = s_axis_tdata[43:26];

  // Sequencer registers.
  logic [NUM_W-1:0] acc_q, acc_d;     // phase accumulator
  logic             post_q, post_d;   // reducing after the run, not before
  logic [NUM_W-1:0] p_q, p_d;         // current kept phase
  logic [CNT_W-1:0] cnt_q, cnt_d;     // scan step within one phase
  logic             iss_q;            // coefficient read in flight is a real tap
  logic signed [SAMPLE_WIDTH-1:0] smp_q;

  logic m_valid_q, m_valid_d;
  logic [SAMPLE_WIDTH-1:0] m_data_q, m_data_d;
  logic m_last_q, m_last_d, m_sat_q, m_sat_d;

  logic s_fire, out_free, mac_clr, issue;
  logic [NUM_W-1:0] p_start;
  logic [NUM_W-1:0] p_next;
  pfr_cell_ctrl_t   cell_ctrl;

  logic signed [SAMPLE_WIDTH-1:0] mac_result;
  logic                           mac_sat;
  logic [COEF_WIDTH-1:0]          ram_rdata;
  logic [ADDR_W-1:0]              ram_waddr, ram_raddr;
  logic                           ram_we;

  assign s_axis_tready = (state_q == S_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;
  assign p_start       = (acc_q == '0) ? '0 : (m_eff - acc_q);
  assign p_next        = p_q + m_eff;
  assign issue         = (state_q == S_MAC) && (NUM_W'(cnt_q) < NUM_W'(MAX_TAPS))
                         && (NUM_W'(cnt_q) < t_eff);

  // Coefficient writes go straight to the RAM, out-of-range rows and taps drop.
  assign ram_we    = s_fire && (s_axis_tuser == REQ_COEF)
                     && (NUM_W'(in_phase) < NUM_W'(MAX_PHASES))
                     && (NUM_W'(in_tap) < NUM_W'(MAX_TAPS));
  assign ram_waddr = ADDR_W'(in_phase) * ADDR_W'(MAX_TAPS) + ADDR_W'(in_tap);
  assign ram_raddr = ADDR_W'(p_q) * ADDR_W'(MAX_TAPS) + ADDR_W'(cnt_q[TAP_W-1:0]);

  always_comb begin
    state_d   = state_q;
    acc_d     = acc_q;
    post_d    = post_q;
    p_d       = p_q;
    cnt_d     = cnt_q;
    mac_clr   = 1'b0;
    cell_ctrl = '0;
    m_valid_d = m_valid_q && !m_axis_tready;
    m_data_d  = m_data_q;
    m_last_d  = m_last_q;
    m_sat_d   = m_sat_q;

    case (state_q)
      S_IDLE: begin
        if (s_fire && (s_axis_tuser == REQ_SAMPLE)) begin
          cell_ctrl.shift = 1'b1;
          post_d  = 1'b0;
          state_d = S_REDUCE;
        end
      end
      S_REDUCE: begin
        // Bring the accumulator below M by repeated subtraction.
        if (acc_q >= m_eff) begin
          acc_d = acc_q - m_eff;
        end else if (post_q) begin
          post_d  = 1'b0;
          state_d = S_IDLE;
        end else if (p_start < l_eff) begin
          p_d     = p_start;
          cnt_d   = '0;
          mac_clr = 1'b1;
          state_d = S_MAC;
        end else begin
          // no kept phase for this sample
          acc_d  = acc_q + l_eff;
          post_d = 1'b1;
        end
      end
      S_MAC: begin
        // Rotate the ring once around so cell 0 shows tap k at step k.
        if (NUM_W'(cnt_q) < NUM_W'(MAX_TAPS)) begin
          cell_ctrl.rotate = 1'b1;
        end
        if (cnt_q == CNT_W'(MAX_TAPS + 2)) begin
          state_d = S_FIN;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      S_FIN: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          m_data_d  = mac_result;
          m_sat_d   = mac_sat;
          m_last_d  = (p_next >= l_eff);
          if (p_next >= l_eff) begin
            acc_d   = acc_q + l_eff;
            post_d  = 1'b1;
            state_d = S_REDUCE;
          end else begin
            p_d     = p_next;
            cnt_d   = '0;
            mac_clr = 1'b1;
            state_d = S_MAC;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      acc_q     <= '0;
      post_q    <= 1'b0;
      p_q       <= '0;
      cnt_q     <= '0;
      iss_q     <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      acc_q     <= acc_d;
      post_q    <= post_d;
      p_q       <= p_d;
      cnt_q     <= cnt_d;
      iss_q     <= issue;
      m_valid_q <= m_valid_d;
    end
  end

  logic [SAMPLE_WIDTH-1:0] taps [MAX_TAPS];

  always_ff @(posedge clk_i) begin
    smp_q    <= taps[0];
    m_data_q <= m_data_d;
    m_last_q <= m_last_d;
    m_sat_q  <= m_sat_d;
  end

  // Delay line: newest sample in cell 0.
  for (genvar i = 0; i < MAX_TAPS; i++) begin : g_cell
    pfr_tap_cell #(
      .W(SAMPLE_WIDTH)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (cell_ctrl),
      .newer_i ((i == 0) ? in_sample : taps[(i == 0) ? 0 : i - 1]),
      .older_i (taps[(i == MAX_TAPS - 1) ? 0 : i + 1]),
      .tap_o   (taps[i])
    );
  end

  pfr_ram #(
    .WIDTH(COEF_WIDTH),
    .DEPTH(DEPTH)
  ) u_coef_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (in_coef),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  pfr_mac #(
    .MAX_TAPS(MAX_TAPS)
  ) u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .clr_i    (mac_clr),
    .vld_i    (iss_q),
    .coef_i   ($signed(ram_rdata)),
    .sample_i (smp_q),
    .result_o (mac_result),
    .sat_o    (mac_sat)
  );

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tlast  = m_last_q;
  assign m_axis_tuser  = m_sat_q;

  `PFR_ASSERT(a_phase_in_range, (state_q != S_MAC) || (p_q < l_eff), "phase beyond L in scan")
  `PFR_ASSERT(a_cnt_bound, NUM_W'(cnt_q) <= NUM_W'(MAX_TAPS + 2), "scan counter overrun")
  `PFR_ASSERT_NEXT(a_idle_acc, (state_q == S_REDUCE) && post_q && (acc_q < m_eff),
                   (state_q == S_IDLE) && (acc_q < m_eff), "accumulator not reduced")
  `PFR_ASSERT_NEXT(a_fin_out, (state_q == S_FIN) && out_free, m_axis_tvalid,
                   "finished phase produced no output")

endmodule

`default_nettype wire

// ===== rtl/pfr_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pfr_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/pfr_tap_cell.sv =====
// ----------------------------------------------------------------------------
// Delay line tap cell
// Hold one sample; shift toward older taps or rotate toward newer ones.
// ----------------------------------------------------------------------------
`default_nettype none

module pfr_tap_cell #(
  parameter int W = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  pfr_pkg::pfr_cell_ctrl_t ctrl_i,
  input  logic [W-1:0]            newer_i,
  input  logic [W-1:0]            older_i,
  output logic [W-1:0]            tap_o
);
  import pfr_pkg::*;

  logic [W-1:0] tap_q, tap_d;

  always_comb begin
    tap_d = tap_q;
    if (ctrl_i.shift) begin
      tap_d = newer_i;
    end else if (ctrl_i.rotate) begin
      tap_d = older_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_q <= '0;
    end else begin
      tap_q <= tap_d;
    end
  end

  assign tap_o = tap_q;

endmodule

`default_nettype wire

// ===== rtl/pfr_mac.sv =====
// ----------------------------------------------------------------------------
// Multiply-accumulate unit
// Registered product, exact accumulation, round and saturate to the output.
// ----------------------------------------------------------------------------
`default_nettype none

module pfr_mac #(
  parameter int MAX_TAPS = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 clr_i,
  input  logic                                 vld_i,
  input  logic signed [pfr_pkg::COEF_WIDTH-1:0]   coef_i,
  input  logic signed [pfr_pkg::SAMPLE_WIDTH-1:0] sample_i,
  output logic signed [pfr_pkg::SAMPLE_WIDTH-1:0] result_o,
  output logic                                 sat_o
);
  import pfr_pkg::*;

  localparam int PROD_W = SAMPLE_WIDTH + COEF_WIDTH;
  localparam int ACC_W  = PROD_W + ((MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 0) + 1;
  localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) <<< (COEF_FRAC - 1);
  localparam logic signed [ACC_W-1:0] HI   = (ACC_W'(1) <<< (SAMPLE_WIDTH - 1)) - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] LO   = -HI - ACC_W'(1);

  logic signed [PROD_W-1:0] prod_q;
  logic                     pv_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [ACC_W-1:0]  rnd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q  <= 1'b0;
      acc_q <= '0;
    end else if (clr_i) begin
      pv_q  <= 1'b0;
      acc_q <= '0;
    end else begin
      pv_q <= vld_i;
      if (pv_q) begin
        acc_q <= acc_q + ACC_W'(prod_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= coef_i * sample_i;
  end

  // Round half up, floor shift, clamp.
  always_comb begin
    rnd = (acc_q + HALF) >>> COEF_FRAC;
    sat_o = 1'b0;
    result_o = rnd[SAMPLE_WIDTH-1:0];
    if (rnd > HI) begin
      result_o = HI[SAMPLE_WIDTH-1:0];
      sat_o = 1'b1;
    end else if (rnd < LO) begin
      result_o = LO[SAMPLE_WIDTH-1:0];
      sat_o = 1'b1;
    end
  end

endmodule

`default_nettype wire

// ===== sim/polyphase_fir_resampler_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Polyphase FIR resampler testbench
// Drives sample and coefficient transactions with random idling on both
// streams, mirrors the resampler in a behavioral predictor and checks every
// output transaction field by field against the oldest predicted output.
// ----------------------------------------------------------------------------
`default_nettype none

module polyphase_fir_resampler_test;
  import pfr_pkg::*;

  localparam int                    CLK_HALF    = 5;
  localparam int                    STALL_LIMIT = 20000;  // cycles without any transaction
  localparam int                    SETTLE      = 200;    // zero-output sample still in flight
  localparam int                    HOLD_CYCLES = 3000;   // long receiver back-pressure
  localparam int                    RAND_ITEMS  = 7;      // per random phase
  localparam logic [CFG_ADDR_W-1:0] REG_UNUSED  = 2'd3;   // no register behind this index

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] value;
    logic                           last;
    logic                           sat;
  } out_beat_t;

  typedef struct {
    pfr_req_e                 req;
    logic signed [15:0]       smp;
    logic [PHASE_IDX_W-1:0]   row;
    logic [TAP_IDX_W-1:0]     tap;
    logic signed [17:0]       coef;
    bit                       typed;   // expected output typed in below
    logic signed [15:0]       exp_val;
    logic                     exp_sat;
  } stim_row_t;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    cfg_we_i;
  logic [CFG_ADDR_W-1:0]   cfg_addr_i;
  logic [CFG_DATA_W-1:0]   cfg_wdata_i;
  logic                    s_axis_tvalid;
  logic                    s_axis_tready;
  // [15:0] sample_in, [20:16] coef_phase, [25:21] coef_tap, [43:26] coef_value
  logic [S_TDATA_W-1:0]    s_axis_tdata;
  // [0] req_type
  logic                    s_axis_tuser;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready;
  // [15:0] sample_out
  logic [SAMPLE_WIDTH-1:0] m_axis_tdata;
  logic                    m_axis_tlast;
  // [0] saturated
  logic                    m_axis_tuser;

  polyphase_fir_resampler i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    clk_i = 1'b1;
    #CLK_HALF;
    clk_i = 1'b0;
    #CLK_HALF;
  end

  // --------------------------------------------------------------------------
  // Predictor state: delay line, coefficient rows, phase accumulator, registers
  // --------------------------------------------------------------------------
  logic signed [SAMPLE_WIDTH-1:0] hist_q [DEF_MAX_TAPS];
  logic signed [COEF_WIDTH-1:0]   rows_q [DEF_MAX_PHASES][DEF_MAX_TAPS];
  int unsigned                    phase_acc_q;
  logic [INTERP_W-1:0]            interp_q;
  logic [DECIM_W-1:0]             decim_q;
  logic [TAPS_W-1:0]              taps_q;
  out_beat_t                      pending_out[$];

  int errors;
  int outputs_seen;
  int samples_sent;
  int sat_seen;

  // Stimulus-side controls read by the stream processes.
  int       send_idle_pct;
  int       recv_stall_pct;
  bit       hold_req;
  bit       typed_on;
  out_beat_t typed_beat;

  task automatic report_mismatch(input string what);
    $display("%0t: MISMATCH %s", $realtime, what);
    errors++;
  endtask

  // Shift a sample in and queue one output per kept polyphase row.
  function automatic void resample_step(input logic signed [SAMPLE_WIDTH-1:0] smp);
    int unsigned l, m, t, a, p;
    longint      sum, r;
    out_beat_t   beat;
    int          first;
    l = (interp_q == 0) ? 1 : (interp_q > DEF_MAX_PHASES ? DEF_MAX_PHASES : interp_q);
    m = (decim_q == 0) ? 1 : (decim_q > DECIM_MAX ? DECIM_MAX : decim_q);
    t = (taps_q == 0) ? 1 : (taps_q > DEF_MAX_TAPS ? DEF_MAX_TAPS : taps_q);
    for (int i = DEF_MAX_TAPS - 1; i > 0; i--) hist_q[i] = hist_q[i-1];
    hist_q[0] = smp;
    a = phase_acc_q % m;
    first = pending_out.size();
    for (p = (m - a) % m; p < l; p += m) begin
      sum = 0;
      for (int k = 0; k < t; k++) sum += longint'(rows_q[p][k]) * longint'(hist_q[k]);
      r = (sum + (longint'(1) << (COEF_FRAC - 1))) >>> COEF_FRAC;
      beat.sat  = 1'b0;
      beat.last = 1'b0;
      if (r > 32767) begin
        r = 32767;
        beat.sat = 1'b1;
      end
      if (r < -32768) begin
        r = -32768;
        beat.sat = 1'b1;
      end
      beat.value = r[15:0];
      pending_out.push_back(beat);
    end
    if (pending_out.size() > first) pending_out[$].last = 1'b1;
    phase_acc_q = ((a + l) % m) & 6'h3f;
  endfunction

  // --------------------------------------------------------------------------
  // Monitor: everything sampled at the rising edge
  // --------------------------------------------------------------------------
  int idle_cycles;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      bit moved;
      moved = 1'b0;
      if (cfg_we_i) begin
        moved = 1'b1;
        case (cfg_addr_i)
          REG_INTERP: interp_q = cfg_wdata_i[INTERP_W-1:0];
          REG_DECIM:  decim_q  = cfg_wdata_i[DECIM_W-1:0];
          REG_TAPS:   taps_q   = cfg_wdata_i[TAPS_W-1:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        moved = 1'b1;
        if (s_axis_tuser == REQ_COEF) begin
          rows_q[s_axis_tdata[20:16]][s_axis_tdata[25:21]] = s_axis_tdata[43:26];
        end else begin
          int base;
          base = pending_out.size();
          resample_step(s_axis_tdata[15:0]);
          // A typed row overrides the predicted beat of that transaction.
          if (typed_on && pending_out.size() > base) pending_out[base] = typed_beat;
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        out_beat_t want;
        moved = 1'b1;
        outputs_seen++;
        if (m_axis_tuser) sat_seen++;
        if (pending_out.size() == 0) begin
          report_mismatch($sformatf("unexpected output %0d", $signed(m_axis_tdata)));
        end else begin
          want = pending_out.pop_front();
          if (m_axis_tdata !== want.value)
            report_mismatch($sformatf("sample_out %0d, want %0d",
                                      $signed(m_axis_tdata), want.value));
          if (m_axis_tlast !== want.last)
            report_mismatch($sformatf("tlast %b, want %b", m_axis_tlast, want.last));
          if (m_axis_tuser !== want.sat)
            report_mismatch($sformatf("saturated %b, want %b", m_axis_tuser, want.sat));
        end
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
        $display("polyphase_fir_resampler_test failed");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: random stalls, plus one long hold to back the block up
  // --------------------------------------------------------------------------
  initial begin
    int held;
    m_axis_tready = 1'b0;
    held = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        held++;
        if (held >= HOLD_CYCLES) begin
          hold_req = 1'b0;
          held = 0;
        end
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender helpers
  // --------------------------------------------------------------------------
  task automatic send_item(input pfr_req_e req, input logic [15:0] smp,
                           input logic [4:0] row, input logic [4:0] tap,
                           input logic [17:0] coef);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req;
    s_axis_tdata  <= {4'b0, coef, tap, row, smp};
    do @(posedge clk_i); while (!s_axis_tready);
    if (req == REQ_SAMPLE) samples_sent++;
  endtask

  task automatic end_burst();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
  endtask

  // Hold until every predicted output is out, then let a trailing
  // zero-output sample finish before touching the registers.
  task automatic drain();
    while (pending_out.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic set_rates(input int l, input int m, input int t);
    write_reg(REG_INTERP, CFG_DATA_W'(l));
    write_reg(REG_DECIM, CFG_DATA_W'(m));
    write_reg(REG_TAPS, CFG_DATA_W'(t));
  endtask

  // Directed rows: passthrough, coefficient extremes, rounding ties.
  stim_row_t directed[$] = '{
    '{REQ_COEF,   16'sd0,      5'd0,  5'd0,  18'sd65536,   0, 16'sd0,      1'b0},
    '{REQ_SAMPLE, 16'sd32767,  5'd0,  5'd0,  18'sd0,       1, 16'sd32767,  1'b0},
    '{REQ_SAMPLE, -16'sd32768, 5'd0,  5'd0,  18'sd0,       1, -16'sd32768, 1'b0},
    '{REQ_SAMPLE, 16'sd0,      5'd0,  5'd0,  18'sd0,       1, 16'sd0,      1'b0},
    '{REQ_SAMPLE, 16'sd1,      5'd0,  5'd0,  18'sd0,       1, 16'sd1,      1'b0},
    '{REQ_COEF,   16'sd0,      5'd0,  5'd0,  18'sd131071,  0, 16'sd0,      1'b0},
    '{REQ_SAMPLE, 16'sd32767,  5'd0,  5'd0,  18'sd0,       1, 16'sd32767,  1'b1},
    '{REQ_SAMPLE, -16'sd32768, 5'd0,  5'd0,  18'sd0,       1, -16'sd32768, 1'b1},
    '{REQ_COEF,   16'sd0,      5'd0,  5'd0,  -18'sd131072, 0, 16'sd0,      1'b0},
    '{REQ_SAMPLE, -16'sd32768, 5'd0,  5'd0,  18'sd0,       1, 16'sd32767,  1'b1},
    '{REQ_SAMPLE, 16'sd32767,  5'd0,  5'd0,  18'sd0,       1, -16'sd32768, 1'b1},
    '{REQ_SAMPLE, 16'sd1,      5'd0,  5'd0,  18'sd0,       1, -16'sd2,     1'b0},
    '{REQ_COEF,   16'sd0,      5'd31, 5'd31, 18'sd0,       0, 16'sd0,      1'b0},
    '{REQ_COEF,   16'sd0,      5'd0,  5'd0,  18'sd32768,   0, 16'sd0,      1'b0},
    '{REQ_SAMPLE, 16'sd1,      5'd0,  5'd0,  18'sd0,       1, 16'sd1,      1'b0},
    '{REQ_SAMPLE, -16'sd1,     5'd0,  5'd0,  18'sd0,       1, 16'sd0,      1'b0},
    '{REQ_SAMPLE, 16'sd12345,  5'd0,  5'd0,  18'sd0,       0, 16'sd0,      1'b0}
  };

  // Random phases: L, M, taps. Includes out-of-range values that clamp,
  // rates with no kept phase on some samples, and the 32-output extreme.
  // Every setting reads only rows and taps covered by the fill below.
  int rate_l[9] = '{1, 3, 2, 4, 32, 4, 63, 0, 7};
  int rate_m[9] = '{1, 2, 3, 1, 64, 64, 0, 127, 5};
  int rate_t[9] = '{32, 8, 5, 8, 1, 3, 0, 63, 1};

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_addr_i     = REG_INTERP;
    cfg_wdata_i    = '0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = REQ_SAMPLE;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req       = 1'b0;
    typed_on       = 1'b0;
    typed_beat     = '0;
    errors         = 0;
    outputs_seen   = 0;
    samples_sent   = 0;
    sat_seen       = 0;
    idle_cycles    = 0;
    phase_acc_q    = 0;
    interp_q       = 1;
    decim_q        = 1;
    taps_q         = 32;
    foreach (hist_q[i]) hist_q[i] = '0;
    foreach (rows_q[i, j]) rows_q[i][j] = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part: single tap, unit rate, so each sample has one output.
    set_rates(1, 1, 1);
    write_reg(REG_UNUSED, 7'h7f);  // must leave every register alone
    foreach (directed[i]) begin
      // Step off the accepting edge so the monitor still sees the previous row.
      #1;
      typed_on   = directed[i].typed;
      typed_beat = '{directed[i].exp_val, 1'b1, directed[i].exp_sat};
      send_item(directed[i].req, directed[i].smp, directed[i].row,
                directed[i].tap, directed[i].coef);
    end
    #1;
    typed_on = 1'b0;
    end_burst();
    drain();

    // Fill the coefficients that the rate settings read: all of row 0,
    // eight taps of rows 1 to 3, tap 0 of every other row.
    for (int r = 0; r < DEF_MAX_PHASES; r++)
      for (int k = 0; k < ((r == 0) ? DEF_MAX_TAPS : ((r < 4) ? 8 : 1)); k++)
        send_item(REQ_COEF, 16'h0, 5'(r), 5'(k), 18'($urandom));
    end_burst();

    for (int ph = 0; ph < 9; ph++) begin
      drain();
      set_rates(rate_l[ph], rate_m[ph], rate_t[ph]);
      case (ph % 4)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 57;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 57;
        end
        default: begin
          send_idle_pct = 31;
          recv_stall_pct = 31;
        end
      endcase
      // Back the output up once while the sender keeps offering.
      if (ph == 1) hold_req = 1'b1;
      for (int n = 0; n < RAND_ITEMS; n++) begin
        logic [15:0] smp;
        case ($urandom_range(7))
          0:       smp = 16'h7fff;
          1:       smp = 16'h8000;
          default: smp = 16'($urandom);
        endcase
        if ($urandom_range(4) == 0)
          send_item(REQ_COEF, 16'h0, 5'($urandom_range(31)), 5'($urandom_range(31)),
                    18'($urandom));
        else
          send_item(REQ_SAMPLE, smp, 5'd0, 5'd0, 18'd0);
      end
      end_burst();
    end
    drain();

    $display("covered %0d samples across 9 rate settings, %0d outputs (%0d saturated)",
             samples_sent, outputs_seen, sat_seen);
    $display("idling on either stream, one long output hold, %0d mismatches", errors);
    if (errors == 0) begin
      $display("polyphase_fir_resampler_test passed");
    end else begin
      $display("polyphase_fir_resampler_test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
